// ----- rtl/linear_fade_envelope_top_defines.svh -----
// Assertion macros used by the RTL top file, which checks itself.
`ifndef LINEAR_FADE_ENVELOPE_TOP_DEFINES_SVH
`define LINEAR_FADE_ENVELOPE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/lfe_pkg.sv -----
package lfe_pkg;

    localparam int MAX_SAMPLE_BITS = 32;

    localparam logic [1:0] FMT_U8    = 2'd0;
    localparam logic [1:0] FMT_S16   = 2'd1;
    localparam logic [1:0] FMT_S32   = 2'd2;
    // Unassigned format code; it behaves like signed 32-bit.
    localparam logic [1:0] FMT_SPARE = 2'd3;

    localparam logic [2:0] REG_FORMAT   = 3'd0;
    localparam logic [2:0] REG_SILENCE  = 3'd1;
    localparam logic [2:0] REG_FADE_IN  = 3'd2;
    localparam logic [2:0] REG_FADE_OUT = 3'd3;
    localparam logic [2:0] REG_SIZE     = 3'd4;

    // Width of the active format.
    localparam logic [1:0] W8  = 2'd0;
    localparam logic [1:0] W16 = 2'd1;
    localparam logic [1:0] W32 = 2'd2;

    // Sideband that travels with each sample through both ramps.
    typedef struct packed {
        logic        last;
        logic [1:0]  wsel;
        logic [30:0] num2;
        logic [30:0] den2;
    } t_side;

endpackage

// ----- rtl/linear_fade_envelope_top.sv -----
// Linear fade-in / fade-out envelope for a stream of audio samples.
// Input channel (i_valid / o_ready) takes one beat per sample: the raw
// sample bits, its position in samples and a last-of-chunk flag.
// Output channel (o_valid / i_ready) returns one beat per input beat, in
// order: the faded sample in the low bits of the format width, upper bits
// zero, and a copy of the flag.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes the format,
// silence level, fade-in end, fade-out start and data size; always ready.
// The user must write it only while empty; the block does not enforce it.
// Each ramp is a pipeline of MAX_SAMPLE_BITS + 3 stages (offset removal,
// one multiplier, one restoring quotient bit per stage, sign and wrap).
// Throughput is one sample per cycle while the receiver does not stall.
// A stall of the receiver freezes the whole pipeline and drops o_ready
// until the waiting output beat is taken; nothing is lost or repeated.
// Synchronous reset empties the pipeline and loads the register defaults
// (signed 16-bit, silence 0, all positions 0).
`include "linear_fade_envelope_top_defines.svh"

module linear_fade_envelope_top #(
    parameter int MAX_SAMPLE_BITS = lfe_pkg::MAX_SAMPLE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_sample_bits,
    input  logic [30:0] i_position,
    input  logic        i_last_of_chunk,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_faded_bits,
    output logic        o_chunk_done
);
    localparam int SW = MAX_SAMPLE_BITS;

    logic [1:0]  r_fmt;
    logic [7:0]  r_silence;
    logic [30:0] r_fade_in;
    logic [30:0] r_fade_out;
    logic [30:0] r_size;

    logic               w_en;
    logic [1:0]         w_wsel;
    logic signed [SW:0] w_dec;
    logic               w_act;
    logic               w_in_ramp;
    logic               w_out_ramp;
    logic [30:0]        w_num1;
    logic [30:0]        w_den1;
    lfe_pkg::t_side     w_side;

    logic               w_v1;
    logic signed [SW:0] w_s1;
    lfe_pkg::t_side     w_sd1;
    logic signed [SW:0] w_s2;
    lfe_pkg::t_side     w_sd2;

    logic               w_out_u8;
    logic               w_out_s16;
    logic               w_out_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt      <= lfe_pkg::FMT_S16;
            r_silence  <= '0;
            r_fade_in  <= '0;
            r_fade_out <= '0;
            r_size     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lfe_pkg::REG_FORMAT:   r_fmt      <= i_cfg_data[1:0];
                lfe_pkg::REG_SILENCE:  r_silence  <= i_cfg_data[7:0];
                lfe_pkg::REG_FADE_IN:  r_fade_in  <= i_cfg_data[30:0];
                lfe_pkg::REG_FADE_OUT: r_fade_out <= i_cfg_data[30:0];
                lfe_pkg::REG_SIZE:     r_size     <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // A 32-bit format that is not built falls back to 16 bits.
    always_comb begin
        case (r_fmt)
            lfe_pkg::FMT_U8:  w_wsel = lfe_pkg::W8;
            lfe_pkg::FMT_S16: w_wsel = lfe_pkg::W16;
            default:          w_wsel = (SW >= 32) ? lfe_pkg::W32 : lfe_pkg::W16;
        endcase
    end

    always_comb begin
        case (w_wsel)
            lfe_pkg::W8:  w_dec = (SW+1)'($signed({1'b0, i_sample_bits[7:0]}));
            lfe_pkg::W16: w_dec = (SW+1)'($signed(i_sample_bits[15:0]));
            default:      w_dec = (SW+1)'($signed(i_sample_bits[SW-1:0]));
        endcase
    end

    // A ramp that does not apply runs with num = den = 1, which is exact.
    assign w_act      = i_position < r_size;
    assign w_in_ramp  = w_act && (i_position < r_fade_in);
    assign w_out_ramp = w_act && (i_position >= r_fade_out);
    assign w_num1     = w_in_ramp ? i_position : 31'd1;
    assign w_den1     = w_in_ramp ? r_fade_in : 31'd1;

    always_comb begin
        w_side.last = i_last_of_chunk;
        w_side.wsel = w_wsel;
        w_side.num2 = w_out_ramp ? (r_size - i_position) : 31'd1;
        w_side.den2 = w_out_ramp ? (r_size - r_fade_out) : 31'd1;
    end

    lfe_ramp #(.SW(SW)) u_fade_in (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_valid),
        .i_sample (w_dec),
        .i_off    (r_silence),
        .i_num    (w_num1),
        .i_den    (w_den1),
        .i_side   (w_side),
        .o_valid  (w_v1),
        .o_sample (w_s1),
        .o_side   (w_sd1)
    );

    lfe_ramp #(.SW(SW)) u_fade_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_v1),
        .i_sample (w_s1),
        .i_off    (r_silence),
        .i_num    (w_sd1.num2),
        .i_den    (w_sd1.den2),
        .i_side   (w_sd1),
        .o_valid  (o_valid),
        .o_sample (w_s2),
        .o_side   (w_sd2)
    );

    always_comb begin
        case (w_sd2.wsel)
            lfe_pkg::W8:  o_faded_bits = 32'(w_s2[7:0]);
            lfe_pkg::W16: o_faded_bits = 32'(w_s2[15:0]);
            default:      o_faded_bits = 32'(w_s2[SW-1:0]);
        endcase
    end

    assign o_chunk_done = w_sd2.last;

    assign w_out_u8    = o_valid && (r_fmt == lfe_pkg::FMT_U8);
    assign w_out_s16   = o_valid && (r_fmt == lfe_pkg::FMT_S16);
    assign w_out_stall = o_valid && !i_ready;

    `ASSERT_IMPLIES(a_u8_upper_zero, i_clk, i_rst_n, w_out_u8, o_faded_bits[31:8] == 24'd0)
    `ASSERT_IMPLIES(a_s16_upper_zero, i_clk, i_rst_n, w_out_s16, o_faded_bits[31:16] == 16'd0)
    `ASSERT_NEXT(a_stall_holds_flag, i_clk, i_rst_n, w_out_stall, o_chunk_done == $past(o_chunk_done) && o_valid)

endmodule

// ----- rtl/lfe_ramp.sv -----
module lfe_ramp #(
    parameter int SW = lfe_pkg::MAX_SAMPLE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [SW:0]   i_sample,
    input  logic [7:0]           i_off,
    input  logic [30:0]          i_num,
    input  logic [30:0]          i_den,
    input  lfe_pkg::t_side       i_side,
    output logic                 o_valid,
    output logic signed [SW:0]   o_sample,
    output lfe_pkg::t_side       o_side
);
    localparam int PW = SW + 31;

    logic signed [SW+1:0] w_diff;
    logic [SW+1:0]        w_abs;

    logic [SW-1:0]  r_mag;
    logic           r_neg0;
    logic [30:0]    r_num;
    logic [30:0]    r_den0;
    lfe_pkg::t_side r_sd0;
    logic           r_vld0;

    // Index 0 is the product stage, 1..SW are the quotient bit stages.
    logic [30:0]    r_rem [0:SW];
    logic [SW-1:0]  r_lo  [0:SW];
    logic [SW-1:0]  r_q   [0:SW];
    logic           r_neg [0:SW];
    logic [30:0]    r_den [0:SW];
    lfe_pkg::t_side r_sd  [0:SW];
    logic           r_vld [0:SW];

    logic signed [SW+1:0] w_res;
    logic signed [SW:0]   w_wrap;
    logic signed [SW:0]   r_out;
    lfe_pkg::t_side       r_osd;
    logic                 r_ovld;
    logic [PW-1:0]        w_prod;

    assign w_diff = (SW+2)'(i_sample) - (SW+2)'($signed({1'b0, i_off}));
    assign w_abs  = w_diff[SW+1] ? (SW+2)'(-w_diff) : w_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (i_en) begin
            r_vld0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag  <= w_abs[SW-1:0];
            r_neg0 <= w_diff[SW+1];
            r_num  <= i_num;
            r_den0 <= i_den;
            r_sd0  <= i_side;
        end
    end

    assign w_prod = PW'(r_mag * r_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= r_vld0;
        end
    end

    // The dividend is below den * 2^SW, so its top bits start below den.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_prod[PW-1:SW];
            r_lo[0]  <= w_prod[SW-1:0];
            r_q[0]   <= '0;
            r_neg[0] <= r_neg0;
            r_den[0] <= r_den0;
            r_sd[0]  <= r_sd0;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= SW; k++) begin : g_div
            logic [31:0] w_trial;
            logic        w_ge;
            logic [31:0] w_sub;

            assign w_trial = {r_rem[k-1], r_lo[k-1][SW-1]};
            assign w_ge    = w_trial >= {1'b0, r_den[k-1]};
            assign w_sub   = w_trial - {1'b0, r_den[k-1]};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? w_sub[30:0] : w_trial[30:0];
                    r_lo[k]  <= {r_lo[k-1][SW-2:0], 1'b0};
                    r_q[k]   <= {r_q[k-1][SW-2:0], w_ge};
                    r_neg[k] <= r_neg[k-1];
                    r_den[k] <= r_den[k-1];
                    r_sd[k]  <= r_sd[k-1];
                end
            end
        end
    endgenerate

    assign w_res = (r_neg[SW] ? -$signed((SW+2)'(r_q[SW])) : $signed((SW+2)'(r_q[SW])))
                   + (SW+2)'($signed({1'b0, i_off}));

    always_comb begin
        case (r_sd[SW].wsel)
            lfe_pkg::W8:  w_wrap = (SW+1)'($signed({1'b0, w_res[7:0]}));
            lfe_pkg::W16: w_wrap = (SW+1)'($signed(w_res[15:0]));
            default:      w_wrap = (SW+1)'($signed(w_res[SW-1:0]));
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_en) begin
            r_ovld <= r_vld[SW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= w_wrap;
            r_osd <= r_sd[SW];
        end
    end

    assign o_valid  = r_ovld;
    assign o_sample = r_out;
    assign o_side   = r_osd;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    typedef struct {
        logic [31:0] bits;
        logic [30:0] pos;
        logic        last;
    } sample_beat_t;

    typedef struct {
        logic [31:0] bits;
        logic        done;
    } faded_beat_t;

    localparam int  PIPE_DEPTH = 2 * (lfe_pkg::MAX_SAMPLE_BITS + 3);
    localparam logic [30:0] POS_MAX = 31'h7FFF_FFFF;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_sample_bits;
    logic [30:0] i_position;
    logic        i_last_of_chunk;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_faded_bits;
    logic        o_chunk_done;

    linear_fade_envelope_top dut (.*);

    // Shadow copy of the block's registers, updated on each config beat.
    logic [1:0]  fmt_q;
    logic [7:0]  silence_q;
    logic [30:0] fade_in_end_q;
    logic [30:0] fade_out_start_q;
    logic [30:0] size_q;

    sample_beat_t pending_samples[$];
    faded_beat_t  faded_expected[$];
    int send_idle_pct;
    int recv_stall_pct;
    int n_sent;
    int n_checked;
    int n_mismatch;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int fmt_width(logic [1:0] f);
        int w;
        if (f == lfe_pkg::FMT_U8) w = 8;
        else if (f == lfe_pkg::FMT_S16) w = 16;
        else w = 32;
        if (w > lfe_pkg::MAX_SAMPLE_BITS) w = 16;
        return w;
    endfunction

    function automatic longint as_signed(logic [31:0] raw, int w);
        if (w == 8) return longint'(raw[7:0]);
        if (w == 16) return longint'(signed'(raw[15:0]));
        return longint'(signed'(raw));
    endfunction

    function automatic logic [31:0] pack_width(longint v, int w);
        logic [31:0] r;
        r = v[31:0];
        if (w == 8) r[31:8] = '0;
        else if (w == 16) r[31:16] = '0;
        return r;
    endfunction

    // Applies fade-in and then fade-out with the current register values.
    function automatic logic [31:0] fade_sample(logic [31:0] raw, logic [30:0] pos);
        int     w;
        longint s;
        longint off;
        longint num;
        longint den;
        w = fmt_width(fmt_q);
        s = as_signed(raw, w);
        off = longint'(silence_q);
        if (pos < size_q) begin
            if (pos < fade_in_end_q) begin
                s = ((s - off) * longint'(pos)) / longint'(fade_in_end_q) + off;
                s = as_signed(pack_width(s, w), w);
            end
            if (pos >= fade_out_start_q) begin
                num = longint'(size_q) - longint'(pos);
                den = longint'(size_q) - longint'(fade_out_start_q);
                s = ((s - off) * num) / den + off;
            end
        end
        return pack_width(s, w);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_sample_bits <= '0;
            i_position <= '0;
            i_last_of_chunk <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_valid <= 1'b1;
                i_sample_bits <= pending_samples[0].bits;
                i_position <= pending_samples[0].pos;
                i_last_of_chunk <= pending_samples[0].last;
                void'(pending_samples.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        faded_beat_t exp_beat;
        if (i_rst_n && i_valid && o_ready) begin
            exp_beat.bits = fade_sample(i_sample_bits, i_position);
            exp_beat.done = i_last_of_chunk;
            faded_expected.push_back(exp_beat);
            n_sent <= n_sent + 1;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (faded_expected.size() == 0) begin
                n_mismatch <= n_mismatch + 1;
                if (n_mismatch < 10)
                    $display("Unexpected output beat: bits %h done %b",
                             o_faded_bits, o_chunk_done);
            end else begin
                exp_beat = faded_expected.pop_front();
                if (exp_beat.bits !== o_faded_bits || exp_beat.done !== o_chunk_done) begin
                    n_mismatch <= n_mismatch + 1;
                    if (n_mismatch < 10)
                        $display("Mismatch on beat %0d: expected %h/%b, got %h/%b",
                                 n_checked, exp_beat.bits, exp_beat.done,
                                 o_faded_bits, o_chunk_done);
                end
            end
            n_checked <= n_checked + 1;
        end
    end

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_samples.size() > 0 || i_valid || faded_expected.size() > 0);
        repeat (PIPE_DEPTH + 10) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(negedge i_clk);
        while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            lfe_pkg::REG_FORMAT:   fmt_q = data[1:0];
            lfe_pkg::REG_SILENCE:  silence_q = data[7:0];
            lfe_pkg::REG_FADE_IN:  fade_in_end_q = data[30:0];
            lfe_pkg::REG_FADE_OUT: fade_out_start_q = data[30:0];
            lfe_pkg::REG_SIZE:     size_q = data[30:0];
            default: ;
        endcase
    endtask

    task automatic push_sample(logic [31:0] bits, logic [30:0] pos, logic last);
        sample_beat_t b;
        b.bits = bits;
        b.pos = pos;
        b.last = last;
        pending_samples.push_back(b);
    endtask

    function automatic logic [30:0] pick_position();
        int sel;
        logic [30:0] hi;
        logic [30:0] p;
        sel = $urandom_range(0, 99);
        hi = (size_q > POS_MAX - 31'd20) ? POS_MAX : size_q + 31'd20;
        if (sel < 65) begin
            p = 31'($urandom_range(0, hi));
        end else if (sel < 80) begin
            case ($urandom_range(0, 3))
                0: p = fade_in_end_q;
                1: p = fade_out_start_q;
                2: p = size_q;
                default: p = 31'd0;
            endcase
            if ($urandom_range(0, 1) && p != 0) p = p - 31'd1;
        end else begin
            p = 31'($urandom() & POS_MAX);
        end
        return p;
    endfunction

    function automatic logic [31:0] pick_bits();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000 | ($urandom() & 32'hFFFF_8080);
            3: return 32'h7FFF_7F7F;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        logic [30:0] cfg_size;
        logic [30:0] cfg_fin;
        logic [30:0] cfg_fout;
        logic [1:0]  cfg_fmt;
        logic [7:0]  cfg_sil;
        int          n_items;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        n_sent = 0;
        n_checked = 0;
        n_mismatch = 0;
        fmt_q = lfe_pkg::FMT_S16;
        silence_q = '0;
        fade_in_end_q = '0;
        fade_out_start_q = '0;
        size_q = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: begin cfg_fmt = lfe_pkg::FMT_S16; cfg_sil = 8'd0;   cfg_fin = 31'd100;
                         cfg_fout = 31'd300; cfg_size = 31'd400; end
                1: begin cfg_fmt = lfe_pkg::FMT_U8;  cfg_sil = 8'd128; cfg_fin = 31'd50;
                         cfg_fout = 31'd20;  cfg_size = 31'd80; end
                2: begin cfg_fmt = lfe_pkg::FMT_S32; cfg_sil = 8'd255; cfg_fin = POS_MAX;
                         cfg_fout = 31'd0;   cfg_size = POS_MAX; end
                3: begin cfg_fmt = lfe_pkg::FMT_SPARE; cfg_sil = 8'd0; cfg_fin = 31'd0;
                         cfg_fout = POS_MAX; cfg_size = POS_MAX; end
                4: begin cfg_fmt = lfe_pkg::FMT_S16; cfg_sil = 8'd255; cfg_fin = 31'd1000;
                         cfg_fout = 31'd1000; cfg_size = 31'd1000; end
                5: begin cfg_fmt = lfe_pkg::FMT_U8;  cfg_sil = 8'd0;   cfg_fin = 31'd0;
                         cfg_fout = 31'd0;   cfg_size = 31'd0; end
                default: begin
                    cfg_fmt = 2'($urandom_range(0, 3));
                    cfg_sil = 8'($urandom_range(0, 255));
                    cfg_size = ($urandom_range(0, 3) == 0) ? 31'($urandom() & POS_MAX)
                                                           : 31'($urandom_range(1, 600));
                    cfg_fin = 31'($urandom_range(0, cfg_size));
                    cfg_fout = 31'($urandom_range(0, cfg_size));
                end
            endcase
            write_reg(lfe_pkg::REG_FORMAT, {30'd0, cfg_fmt});
            write_reg(lfe_pkg::REG_SILENCE, {24'd0, cfg_sil});
            write_reg(lfe_pkg::REG_FADE_IN, {1'b0, cfg_fin});
            write_reg(lfe_pkg::REG_FADE_OUT, {1'b0, cfg_fout});
            write_reg(lfe_pkg::REG_SIZE, {1'b0, cfg_size});

            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase

            // Boundary positions and extreme samples for the first three fixed settings.
            if (ph < 3) begin
                push_sample(32'h0000_0000, 31'd0, 1'b0);
                push_sample(32'hFFFF_FFFF, cfg_fin == 0 ? 31'd0 : cfg_fin - 31'd1, 1'b1);
                push_sample(32'h8000_8080, cfg_fin, 1'b0);
                push_sample(32'h7FFF_7F7F, cfg_fout, 1'b1);
                push_sample(32'h8000_8000, cfg_size == 0 ? 31'd0 : cfg_size - 31'd1, 1'b0);
                push_sample(32'h7FFF_FFFF, cfg_size, 1'b1);
                push_sample(32'hA5A5_5A5A, POS_MAX, 1'b0);
            end

            n_items = 120;
            for (int k = 0; k < n_items; k++) begin
                push_sample(pick_bits(), pick_position(), 1'($urandom_range(0, 1)));
                // In phase 6 the sender holds off mid-phase until the pipeline has emptied.
                if (ph == 6 && k == n_items / 2) begin
                    do @(negedge i_clk);
                    while (pending_samples.size() > 0 || i_valid
                           || faded_expected.size() > 0);
                end
            end
            wait_drained();
        end

        $display("Covered %0d samples over 12 register settings, all formats,", n_sent);
        $display("overlapping and empty fade regions, with sender and receiver stalls.");
        if (n_mismatch == 0 && faded_expected.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
